// ----- hdl/intrusion_alarm_sequencer_top_assert.svh -----
// assertion macros for the intrusion alarm sequencer
`ifndef INTRUSION_ALARM_SEQUENCER_TOP_ASSERT_SVH
`define INTRUSION_ALARM_SEQUENCER_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define IAS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the following cycle
`define IAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ias_pkg.sv -----
// types, constants and helpers shared by the intrusion alarm sequencer
package ias_pkg;

    localparam int unsigned MS_W      = 16;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned COUNT_W   = 6;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [COUNT_W-1:0] LINE_MAX = 6'd63;

    localparam logic [CHAR_W-1:0] CHAR_CR   = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_LF   = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_ONE  = 8'h31;

    // bit positions of the pin level word
    localparam int unsigned PIN_YELLOW = 0;
    localparam int unsigned PIN_RED    = 1;
    localparam int unsigned PIN_LASER  = 2;
    localparam int unsigned PIN_TILT   = 3;

    localparam logic [MS_W-1:0] NORMAL_BLINK_RST   = 16'd1000;
    localparam logic [MS_W-1:0] DISARMED_BLINK_RST = 16'd1500;
    localparam logic [MS_W-1:0] ALARM_BLINK_RST    = 16'd100;
    localparam logic [MS_W-1:0] ALERT_HOLD_RST     = 16'd1000;
    localparam logic [MS_W-1:0] SENSOR_HOLDOFF_RST = 16'd1000;
    localparam logic [MS_W-1:0] TILT_RELEASE_RST   = 16'd1500;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORMAL_BLINK   = 3'd0,
        REG_DISARMED_BLINK = 3'd1,
        REG_ALARM_BLINK    = 3'd2,
        REG_ALERT_HOLD     = 3'd3,
        REG_SENSOR_HOLDOFF = 3'd4,
        REG_TILT_RELEASE   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [MS_W-1:0] normal_blink_ms;
        logic [MS_W-1:0] disarmed_blink_ms;
        logic [MS_W-1:0] alarm_blink_ms;
        logic [MS_W-1:0] alert_hold_ms;
        logic [MS_W-1:0] sensor_holdoff_ms;
        logic [MS_W-1:0] tilt_release_ms;
    } cfg_t;

    typedef struct packed {
        logic [MS_W-1:0]   elapsed_ms;
        logic              rx_valid;
        logic [CHAR_W-1:0] rx_byte;
        logic              tilt_level;
        logic              laser_level;
    } item_t;

    typedef struct packed {
        logic yellow_led;
        logic red_led;
        logic laser_enable;
        logic tilt_echo;
        logic tilt_alarm;
        logic laser_alarm;
    } result_t;

    typedef struct packed {
        logic               armed;
        logic               alert_active;
        logic [MS_W-1:0]    alert_left;
        logic [MS_W-1:0]    tilt_cool_left;
        logic [MS_W-1:0]    tilt_quiet_left;
        logic [MS_W-1:0]    laser_cool_left;
        logic [MS_W-1:0]    blink_left;
        logic [MS_W-1:0]    blink_period;
        logic               blink_phase;
        logic               yellow_allowed;
        logic               red_allowed;
        logic [CHAR_W-1:0]  first_char;
        logic [COUNT_W-1:0] char_count;
        logic [3:0]         pin_levels;
    } state_t;

    localparam state_t STATE_RST = '{
        armed:           1'b1,
        alert_active:    1'b0,
        alert_left:      '0,
        tilt_cool_left:  '0,
        tilt_quiet_left: '0,
        laser_cool_left: '0,
        blink_left:      '0,
        blink_period:    NORMAL_BLINK_RST,
        blink_phase:     1'b0,
        yellow_allowed:  1'b1,
        red_allowed:     1'b1,
        first_char:      '0,
        char_count:      '0,
        pin_levels:      4'b0100
    };

    // saturating countdown
    function automatic logic [MS_W-1:0] count_down(input logic [MS_W-1:0] v,
                                                   input logic [MS_W-1:0] d);
        return (v > d) ? (v - d) : '0;
    endfunction

endpackage

// ----- hdl/intrusion_alarm_sequencer_top.sv -----
// top level of the intrusion alarm sequencer
// One request on the slave stream is one polling tick and yields exactly one result on the
// master stream. A tick is taken into an input register, then worked out combinationally into
// the result register and the sequencer state, so one tick per clock is sustained while
// results are taken; a result is offered from the result register once its tick has passed
// through the input register. The state update of a tick is a single pass of saturating subtracts
// and compares; that pass is what sets the cycle time. With a result waiting, one further
// request is still taken into the input register. Configuration registers are always ready; a
// written value only takes effect when it is next loaded into a countdown or the blink period.
module intrusion_alarm_sequencer_top
    import ias_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // tick requests
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,  // elapsed_ms[15:0], rx_byte[23:16], tilt_level[24],
                                           // laser_level[25], zero fill
    input  logic [0:0]           s_tuser,  // rx_valid[0]
    // results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,  // yellow_led[0], red_led[1], laser_enable[2],
                                           // tilt_echo[3], tilt_alarm[4], laser_alarm[5], zero fill
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MS_W-1:0]      cfg_data
);

    `include "intrusion_alarm_sequencer_top_assert.svh"

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    load;

    ias_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ias_step u_step (
        .state_cur  (state_reg),
        .cfg        (cfg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    // handshake: result register frees up when taken, input register when it moves on
    assign advance  = !out_valid_reg || m_tready;
    assign load     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RST;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (load) begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.elapsed_ms  <= s_tdata[15:0];
            in_item_reg.rx_byte     <= s_tdata[23:16];
            in_item_reg.tilt_level  <= s_tdata[24];
            in_item_reg.laser_level <= s_tdata[25];
            in_item_reg.rx_valid    <= s_tuser[0];
        end
        if (load) begin
            out_res_reg <= res_next;
        end
    end

    // result packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_res_reg.laser_alarm,
                       out_res_reg.tilt_alarm,
                       out_res_reg.tilt_echo,
                       out_res_reg.laser_enable,
                       out_res_reg.red_led,
                       out_res_reg.yellow_led};

    // checks
    `IAS_ASSERT_SAME(a_laser_pin_follows_armed, aclk, aresetn, 1'b1, state_reg.pin_levels[PIN_LASER] == state_reg.armed, "laser pin differs from armed state")
    `IAS_ASSERT_NEXT(a_alarm_starts_alert, aclk, aresetn, load && (res_next.tilt_alarm || res_next.laser_alarm), state_reg.alert_active, "alarm fired without an active alert")
    `IAS_ASSERT_NEXT(a_alarm_only_armed, aclk, aresetn, load && (res_next.tilt_alarm || res_next.laser_alarm), state_reg.armed, "alarm fired while disarmed")
    `IAS_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !out_valid_reg, s_tready, "request stalled with empty result register")

endmodule

// ----- hdl/ias_cfg.sv -----
// configuration register file
module ias_cfg
    import ias_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MS_W-1:0]      cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.normal_blink_ms   <= NORMAL_BLINK_RST;
            cfg_reg.disarmed_blink_ms <= DISARMED_BLINK_RST;
            cfg_reg.alarm_blink_ms    <= ALARM_BLINK_RST;
            cfg_reg.alert_hold_ms     <= ALERT_HOLD_RST;
            cfg_reg.sensor_holdoff_ms <= SENSOR_HOLDOFF_RST;
            cfg_reg.tilt_release_ms   <= TILT_RELEASE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_NORMAL_BLINK:   cfg_reg.normal_blink_ms   <= cfg_data;
                REG_DISARMED_BLINK: cfg_reg.disarmed_blink_ms <= cfg_data;
                REG_ALARM_BLINK:    cfg_reg.alarm_blink_ms    <= cfg_data;
                REG_ALERT_HOLD:     cfg_reg.alert_hold_ms     <= cfg_data;
                REG_SENSOR_HOLDOFF: cfg_reg.sensor_holdoff_ms <= cfg_data;
                REG_TILT_RELEASE:   cfg_reg.tilt_release_ms   <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ----- hdl/ias_step.sv -----
// next-state and result logic for one polling tick
module ias_step
    import ias_pkg::*;
(
    input  state_t  state_cur,
    input  cfg_t    cfg,
    input  item_t   item,
    output state_t  state_next,
    output result_t result
);

    always_comb begin
        state_t s;
        logic   tilt_fired;
        logic   laser_fired;
        logic   line_end;

        s           = state_cur;
        tilt_fired  = 1'b0;
        laser_fired = 1'b0;
        line_end    = (item.rx_byte == CHAR_CR) || (item.rx_byte == CHAR_LF);

        // all countdowns drop by the elapsed time
        s.tilt_cool_left  = count_down(s.tilt_cool_left, item.elapsed_ms);
        s.tilt_quiet_left = count_down(s.tilt_quiet_left, item.elapsed_ms);
        s.laser_cool_left = count_down(s.laser_cool_left, item.elapsed_ms);
        s.blink_left      = count_down(s.blink_left, item.elapsed_ms);
        s.alert_left      = count_down(s.alert_left, item.elapsed_ms);

        // blinker toggle
        if (s.blink_left == '0) begin
            s.blink_left             = s.blink_period;
            s.blink_phase            = !s.blink_phase;
            s.pin_levels[PIN_YELLOW] = s.blink_phase && s.yellow_allowed;
            s.pin_levels[PIN_RED]    = s.blink_phase && s.red_allowed;
        end

        // command line gathering
        if (item.rx_valid) begin
            if (line_end) begin
                if (s.char_count != '0) begin
                    if (s.first_char == CHAR_ZERO) begin
                        s.red_allowed    = 1'b0;
                        s.yellow_allowed = 1'b1;
                        s.blink_period   = cfg.disarmed_blink_ms;
                        s.armed          = 1'b0;
                    end else if (s.first_char == CHAR_ONE) begin
                        s.armed = 1'b1;
                    end
                end
                s.pin_levels[PIN_LASER] = s.armed;
                s.char_count            = '0;
            end else if (s.char_count < LINE_MAX) begin
                if (s.char_count == '0) begin
                    s.first_char = item.rx_byte;
                end
                s.char_count = s.char_count + 6'd1;
            end
        end

        // alert expiry and sensors, only while armed
        if (s.armed) begin
            if (s.alert_active && (s.alert_left == '0)) begin
                s.red_allowed    = 1'b1;
                s.yellow_allowed = 1'b1;
                s.blink_period   = cfg.normal_blink_ms;
                s.alert_active   = 1'b0;
            end
            s.pin_levels[PIN_TILT] = item.tilt_level;
            if (s.tilt_cool_left == '0) begin
                if ((s.tilt_quiet_left == '0) && !item.tilt_level) begin
                    s.alert_active   = 1'b1;
                    s.alert_left     = cfg.alert_hold_ms;
                    s.red_allowed    = 1'b1;
                    s.yellow_allowed = 1'b0;
                    s.blink_period   = cfg.alarm_blink_ms;
                    s.tilt_cool_left = cfg.sensor_holdoff_ms;
                    tilt_fired       = 1'b1;
                end else if (item.tilt_level) begin
                    s.tilt_quiet_left = cfg.tilt_release_ms;
                end
            end
            if ((s.laser_cool_left == '0) && item.laser_level) begin
                s.alert_active    = 1'b1;
                s.alert_left      = cfg.alert_hold_ms;
                s.red_allowed     = 1'b1;
                s.yellow_allowed  = 1'b0;
                s.blink_period    = cfg.alarm_blink_ms;
                s.laser_cool_left = cfg.sensor_holdoff_ms;
                laser_fired       = 1'b1;
            end
        end

        state_next          = s;
        result.yellow_led   = s.pin_levels[PIN_YELLOW];
        result.red_led      = s.pin_levels[PIN_RED];
        result.laser_enable = s.pin_levels[PIN_LASER];
        result.tilt_echo    = s.pin_levels[PIN_TILT];
        result.tilt_alarm   = tilt_fired;
        result.laser_alarm  = laser_fired;
    end

endmodule

// ----- test/tb_intrusion_alarm_sequencer_top.sv -----
// self-checking testbench for the intrusion alarm sequencer top level
module tb_intrusion_alarm_sequencer_top
    import ias_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PLAN_LEN     = 20;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLD_MARK    = 300;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          PHASE_TICKS  = 113;
    localparam logic [15:0] MS_MAX       = 16'hFFFF;

    typedef enum {SET_SMALL, SET_ZERO, SET_MAX, SET_MIXED} setting_kind_t;

    typedef struct {
        item_t   tick;
        bit      typed;
        result_t want;
    } plan_row_t;

    // directed ticks; typed rows carry their own expected result
    plan_row_t plan_rows [PLAN_LEN] = '{
        '{'{16'd0,    1'b0, 8'h00,     1'b1, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{'{MS_MAX,   1'b0, 8'h00,     1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{'{16'd0,    1'b0, 8'h00,     1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{16'd1500, 1'b0, 8'h00,     1'b0, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{'{16'd0,    1'b0, 8'h00,     1'b1, 1'b1}, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}},
        // disarm command, then sensors while disarmed
        '{'{16'd0,    1'b1, CHAR_ZERO, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd0,    1'b1, CHAR_CR,   1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd0,    1'b0, 8'h00,     1'b0, 1'b1}, 1'b0, '0},
        // unknown command, empty line, unknown command with all ones byte
        '{'{16'd0,    1'b1, 8'h00,     1'b1, 1'b1}, 1'b0, '0},
        '{'{16'd0,    1'b1, CHAR_LF,   1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd0,    1'b1, CHAR_CR,   1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd1700, 1'b1, 8'hFF,     1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd0,    1'b1, CHAR_LF,   1'b1, 1'b0}, 1'b0, '0},
        // arm again, alert runs out, both sensors fire together
        '{'{16'd0,    1'b1, CHAR_ONE,  1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd0,    1'b1, CHAR_CR,   1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd2000, 1'b0, 8'h00,     1'b1, 1'b0}, 1'b0, '0},
        '{'{MS_MAX,   1'b0, 8'h00,     1'b0, 1'b1}, 1'b0, '0},
        // arm while already armed
        '{'{16'd100,  1'b1, CHAR_ONE,  1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd100,  1'b1, CHAR_CR,   1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd1,    1'b0, 8'h00,     1'b1, 1'b0}, 1'b0, '0}
    };

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;  // elapsed_ms[15:0], rx_byte[23:16], tilt_level[24],
                                           // laser_level[25], zero fill
    logic [0:0]           s_tuser   = '0;  // rx_valid[0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;         // yellow_led[0], red_led[1], laser_enable[2],
                                           // tilt_echo[3], tilt_alarm[4], laser_alarm[5]
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MS_W-1:0]      cfg_data  = '0;

    // predictor copy of the registers and the sequencer state
    cfg_t            reg_copy;
    logic            sys_armed, alert_on, blink_on, yellow_ok, red_ok;
    logic [15:0]     alert_ms, tilt_cool_ms, tilt_quiet_ms, laser_cool_ms, blink_ms, blink_half;
    logic [7:0]      line_first;
    logic [5:0]      line_len;
    logic            pin_yellow, pin_red, pin_laser, pin_tilt;

    result_t         pending_results [$];
    int              ticks_sent, results_checked, settings_applied, alarm_events;
    int              mismatches, cycle_count;
    bit              sender_steady, receiver_steady, hold_done;

    intrusion_alarm_sequencer_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("intrusion_alarm_sequencer_top: mismatch");
            $finish;
        end
    end

    function automatic logic [15:0] sat_sub(input logic [15:0] v, input logic [15:0] d);
        return (v > d) ? 16'(v - d) : 16'd0;
    endfunction

    task automatic clear_sequencer();
        reg_copy = '{NORMAL_BLINK_RST, DISARMED_BLINK_RST, ALARM_BLINK_RST,
                     ALERT_HOLD_RST, SENSOR_HOLDOFF_RST, TILT_RELEASE_RST};
        sys_armed     = 1'b1;
        alert_on      = 1'b0;
        alert_ms      = '0;
        tilt_cool_ms  = '0;
        tilt_quiet_ms = '0;
        laser_cool_ms = '0;
        blink_ms      = '0;
        blink_half    = NORMAL_BLINK_RST;
        blink_on      = 1'b0;
        yellow_ok     = 1'b1;
        red_ok        = 1'b1;
        line_first    = '0;
        line_len      = '0;
        pin_yellow    = 1'b0;
        pin_red       = 1'b0;
        pin_laser     = 1'b1;
        pin_tilt      = 1'b0;
    endtask

    function automatic void raise_alert();
        alert_on   = 1'b1;
        alert_ms   = reg_copy.alert_hold_ms;
        red_ok     = 1'b1;
        yellow_ok  = 1'b0;
        blink_half = reg_copy.alarm_blink_ms;
    endfunction

    // one polling tick of the sequencer, returns the pin levels and event flags
    function automatic result_t sequencer_tick(input item_t t);
        result_t r;
        logic    tilt_hit, laser_hit;
        tilt_hit  = 1'b0;
        laser_hit = 1'b0;

        tilt_cool_ms  = sat_sub(tilt_cool_ms, t.elapsed_ms);
        tilt_quiet_ms = sat_sub(tilt_quiet_ms, t.elapsed_ms);
        laser_cool_ms = sat_sub(laser_cool_ms, t.elapsed_ms);
        blink_ms      = sat_sub(blink_ms, t.elapsed_ms);
        alert_ms      = sat_sub(alert_ms, t.elapsed_ms);

        // blinker toggles when its countdown has run out
        if (blink_ms == 0) begin
            blink_ms   = blink_half;
            blink_on   = !blink_on;
            pin_yellow = blink_on && yellow_ok;
            pin_red    = blink_on && red_ok;
        end

        // command line gathering
        if (t.rx_valid) begin
            if (t.rx_byte == CHAR_CR || t.rx_byte == CHAR_LF) begin
                if (line_len != 0) begin
                    if (line_first == CHAR_ZERO) begin
                        red_ok     = 1'b0;
                        yellow_ok  = 1'b1;
                        blink_half = reg_copy.disarmed_blink_ms;
                        sys_armed  = 1'b0;
                    end else if (line_first == CHAR_ONE) begin
                        sys_armed = 1'b1;
                    end
                end
                pin_laser = sys_armed;
                line_len  = '0;
            end else if (line_len < LINE_MAX) begin
                if (line_len == 0)
                    line_first = t.rx_byte;
                line_len = line_len + 6'd1;
            end
        end

        // alert expiry and sensors only while armed
        if (sys_armed) begin
            if (alert_on && alert_ms == 0) begin
                red_ok     = 1'b1;
                yellow_ok  = 1'b1;
                blink_half = reg_copy.normal_blink_ms;
                alert_on   = 1'b0;
            end
            pin_tilt = t.tilt_level;
            if (tilt_cool_ms == 0) begin
                if (tilt_quiet_ms == 0 && !t.tilt_level) begin
                    raise_alert();
                    tilt_cool_ms = reg_copy.sensor_holdoff_ms;
                    tilt_hit     = 1'b1;
                end else if (t.tilt_level) begin
                    tilt_quiet_ms = reg_copy.tilt_release_ms;
                end
            end
            if (laser_cool_ms == 0 && t.laser_level) begin
                raise_alert();
                laser_cool_ms = reg_copy.sensor_holdoff_ms;
                laser_hit     = 1'b1;
            end
        end

        if (tilt_hit || laser_hit)
            alarm_events++;
        r.yellow_led   = pin_yellow;
        r.red_led      = pin_red;
        r.laser_enable = pin_laser;
        r.tilt_echo    = pin_tilt;
        r.tilt_alarm   = tilt_hit;
        r.laser_alarm  = laser_hit;
        return r;
    endfunction

    function automatic logic [15:0] pick_elapsed();
        int unsigned d;
        d = $urandom_range(0, 99);
        if (d < 10)
            return 16'd0;
        else if (d < 15)
            return MS_MAX;
        else if (d < 25)
            return 16'($urandom_range(0, 65535));
        else
            return 16'($urandom_range(1, 600));
    endfunction

    function automatic item_t make_tick(input logic rx_v, input logic [7:0] b);
        item_t t;
        t.elapsed_ms  = pick_elapsed();
        t.rx_valid    = rx_v;
        t.rx_byte     = b;
        t.tilt_level  = ($urandom_range(0, 99) < 70);
        t.laser_level = ($urandom_range(0, 99) < 12);
        return t;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CHAR_CR || b == CHAR_LF);
        return b;
    endfunction

    function automatic logic [7:0] line_end();
        return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
    endfunction

    // offer one tick request, predict it on acceptance, then idle for a drawn gap
    task automatic send_tick(input item_t t, input bit typed, input result_t want);
        result_t due;
        int      gap;
        s_tdata  <= {6'd0, t.laser_level, t.tilt_level, t.rx_byte, t.elapsed_ms};
        s_tuser  <= t.rx_valid;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        due = sequencer_tick(t);
        if (typed)
            due = want;
        pending_results.push_back(due);
        ticks_sent++;
        @(negedge aclk);
        gap = sender_steady ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 99) < 3)
            sender_steady = !sender_steady;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_random(input logic rx_v, input logic [7:0] b);
        send_tick(make_tick(rx_v, b), 1'b0, '0);
    endtask

    // stop offering and wait until every expected result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // a command line: first character, some filler, then a line end
    task automatic send_line(input logic [7:0] first, input int extra);
        send_random(1'b1, first);
        for (int i = 0; i < extra; i++) begin
            if ($urandom_range(0, 99) < 30)
                send_random(1'b0, 8'($urandom_range(0, 255)));
            send_random(1'b1, plain_char());
        end
        send_random(1'b1, line_end());
    endtask

    // configuration write; valid stays high for the next write
    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            REG_NORMAL_BLINK:   reg_copy.normal_blink_ms   = val;
            REG_DISARMED_BLINK: reg_copy.disarmed_blink_ms = val;
            REG_ALARM_BLINK:    reg_copy.alarm_blink_ms    = val;
            REG_ALERT_HOLD:     reg_copy.alert_hold_ms     = val;
            REG_SENSOR_HOLDOFF: reg_copy.sensor_holdoff_ms = val;
            REG_TILT_RELEASE:   reg_copy.tilt_release_ms   = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_setting(input setting_kind_t kind);
        int unsigned d;
        d = $urandom_range(0, 3);
        case (kind)
            SET_ZERO:  return 16'd0;
            SET_MAX:   return MS_MAX;
            SET_SMALL: return 16'($urandom_range(0, 2500));
            default:   return (d == 0) ? 16'd0 :
                              (d == 1) ? 16'($urandom_range(0, 65535)) :
                                         16'($urandom_range(1, 2500));
        endcase
    endfunction

    // new register set, written while the block is idle
    task automatic apply_settings(input setting_kind_t kind);
        drain_results();
        repeat (4) @(negedge aclk);
        write_reg(REG_NORMAL_BLINK,   pick_setting(kind));
        write_reg(REG_DISARMED_BLINK, pick_setting(kind));
        write_reg(REG_ALARM_BLINK,    pick_setting(kind));
        write_reg(REG_ALERT_HOLD,     pick_setting(kind));
        write_reg(REG_SENSOR_HOLDOFF, pick_setting(kind));
        write_reg(REG_TILT_RELEASE,   pick_setting(kind));
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // random mix of command lines, empty lines, long lines, noise and sensor ticks
    task automatic run_phase(input int count, input bit with_long, input bit mid_pause);
        int          start;
        int unsigned sel;
        bit          paused;
        logic [7:0]  cmd;
        start  = ticks_sent;
        paused = 1'b0;
        if (with_long)
            send_line($urandom_range(0, 1) ? CHAR_ZERO : CHAR_ONE, $urandom_range(63, 70));
        while (ticks_sent - start < count) begin
            if (mid_pause && !paused && ticks_sent - start >= count / 2) begin
                drain_results();
                paused = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                sel = $urandom_range(0, 99);
                cmd = (sel < 40) ? CHAR_ONE : (sel < 65) ? CHAR_ZERO : plain_char();
                send_line(cmd, $urandom_range(0, 3));
            end else if (sel < 50) begin
                send_random(1'b1, line_end());
            end else if (sel < 53) begin
                send_line(plain_char(), $urandom_range(62, 68));
            end else if (sel < 60) begin
                send_random(1'b1, 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_random(1'b0, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic check_bit(input string field, input logic want, input logic got);
        if (want !== got) begin
            $error("%s: expected %0b, got %0b", field, want, got);
            mismatches++;
        end
    endtask

    // result side: random ready gaps, one long hold-off, field by field compare
    initial begin
        int      gap;
        result_t due;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            gap = receiver_steady ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 99) < 3)
                receiver_steady = !receiver_steady;
            if (!hold_done && results_checked >= HOLD_MARK) begin
                gap       = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid)
                @(posedge aclk);
            if (pending_results.size() == 0) begin
                $error("result 0x%02h with no request waiting", m_tdata);
                mismatches++;
            end else begin
                due = pending_results.pop_front();
                check_bit("yellow_led",   due.yellow_led,   m_tdata[0]);
                check_bit("red_led",      due.red_led,      m_tdata[1]);
                check_bit("laser_enable", due.laser_enable, m_tdata[2]);
                check_bit("tilt_echo",    due.tilt_echo,    m_tdata[3]);
                check_bit("tilt_alarm",   due.tilt_alarm,   m_tdata[4]);
                check_bit("laser_alarm",  due.laser_alarm,  m_tdata[5]);
            end
            results_checked++;
            @(negedge aclk);
        end
    end

    // main sequence
    initial begin
        ticks_sent       = 0;
        results_checked  = 0;
        settings_applied = 0;
        alarm_events     = 0;
        mismatches       = 0;
        sender_steady    = 1'b0;
        receiver_steady  = 1'b0;
        hold_done        = 1'b0;
        clear_sequencer();

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part at reset register values
        for (int i = 0; i < PLAN_LEN; i++)
            send_tick(plan_rows[i].tick, plan_rows[i].typed, plan_rows[i].want);

        run_phase(PHASE_TICKS + 2, 1'b1, 1'b1);
        apply_settings(SET_SMALL);
        run_phase(PHASE_TICKS, 1'b0, 1'b0);
        apply_settings(SET_ZERO);
        run_phase(PHASE_TICKS, 1'b0, 1'b0);
        apply_settings(SET_MAX);
        run_phase(PHASE_TICKS, 1'b0, 1'b0);
        apply_settings(SET_SMALL);
        run_phase(PHASE_TICKS, 1'b0, 1'b0);
        apply_settings(SET_MIXED);
        run_phase(PHASE_TICKS, 1'b0, 1'b0);

        drain_results();
        repeat (8) @(posedge aclk);

        $display("ran %0d ticks over %0d register sets, %0d results compared",
                 ticks_sent, settings_applied + 1, results_checked);
        $display("predicted %0d alarm events; zero and full scale registers included",
                 alarm_events);
        if (mismatches == 0) begin
            $display("intrusion_alarm_sequencer_top: match");
        end else begin
            $display("intrusion_alarm_sequencer_top: mismatch");
        end
        $finish;
    end

endmodule

// ----- intrusion_alarm_sequencer_top.f -----
+incdir+hdl
hdl/ias_pkg.sv
hdl/ias_cfg.sv
hdl/ias_step.sv
hdl/intrusion_alarm_sequencer_top.sv
test/tb_intrusion_alarm_sequencer_top.sv
